### design/tcl_pkg.sv
// shared constants, types and helpers of the text console line buffer
`timescale 1ns / 1ps
package tcl_pkg;

  localparam int unsigned ROWS   = 32;
  localparam int unsigned COLS   = 64;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLS + 1);
  localparam int unsigned RCOL_W = $clog2(COLS);
  localparam int unsigned ADDR_W = $clog2(ROWS * COLS);
  localparam int unsigned VIS_W  = 6;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned DLT_W  = 7;

  localparam logic [CH_W-1:0]  CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0]  CH_BACKSPACE = 8'd8;
  localparam logic [VIS_W-1:0] VIS_RESET    = 6'd32;

  typedef enum logic [1:0] {
    FN_PUT    = 2'd0,
    FN_SCROLL = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  // store updates requested by the cursor logic
  typedef struct packed {
    logic             text_we;
    logic             len_we;
    logic             clear;
    logic [ROW_W-1:0] wr_row;
    logic [COL_W-1:0] wr_col;
    logic [COL_W-1:0] len_val;
  } upd_t;

  // cursor and view state
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] base;
  } cur_t;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                 input logic [ROW_W-1:0] lrow);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, lrow};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

endpackage

### design/text_console_line_buffer_unit.sv
// top level of the text console line buffer
`timescale 1ns / 1ps
// Text console line buffer. Each input transaction puts a character, scrolls the view,
// reads one cell or clears the console, and gives exactly one result transaction with
// the cursor, view top, a row length and the read byte. The result is loaded into the
// output register after the input is accepted and the text and row length memories
// return registered read data; a new item is taken only once the last result is loaded.
// A finished result waits in the output register while the next item is taken; while
// it is held back, the item after that stalls the input. Row lengths are cleared at once
// through per-row valid bits; no clearing pass follows reset. The user must write the
// visible row count through cfg_we_i only while the block is idle; it is not enforced.
module text_console_line_buffer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [tcl_pkg::CH_W-1:0]     char_code_i,
  input  logic signed [tcl_pkg::DLT_W-1:0] scroll_delta_i,
  input  logic [tcl_pkg::ROW_W-1:0]    read_row_i,
  input  logic [tcl_pkg::RCOL_W-1:0]   read_col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tcl_pkg::ROW_W-1:0]    cursor_row_out_o,
  output logic [tcl_pkg::COL_W-1:0]    cursor_col_out_o,
  output logic [tcl_pkg::ROW_W-1:0]    view_top_out_o,
  output logic [tcl_pkg::COL_W-1:0]    row_length_o,
  output logic [tcl_pkg::CH_W-1:0]     cell_char_o,
  input  logic                         cfg_we_i,
  input  logic [tcl_pkg::VIS_W-1:0]    cfg_wdata_i
);

  logic                        acc, rd_acc, load;
  tcl_pkg::func_e              func;
  tcl_pkg::upd_t               upd;
  tcl_pkg::cur_t               st;
  logic [tcl_pkg::ROW_W-1:0]   rphys;
  logic [tcl_pkg::ADDR_W-1:0]  t_waddr, t_raddr;
  logic [tcl_pkg::CH_W-1:0]    t_rdata;
  logic [tcl_pkg::COL_W-1:0]   l_rdata;

  logic                        busy_q, rd_q, rvld_q, rok_q, out_valid_q;
  logic [tcl_pkg::RCOL_W-1:0]  rcol_q;
  logic [tcl_pkg::ROWS-1:0]    vld_q;
  logic [tcl_pkg::COL_W-1:0]   len_sel;
  logic [tcl_pkg::CH_W-1:0]    cell_byte;

  logic [tcl_pkg::ROW_W-1:0]   o_row_q, o_top_q;
  logic [tcl_pkg::COL_W-1:0]   o_col_q, o_len_q;
  logic [tcl_pkg::CH_W-1:0]    o_cell_q;

  assign func       = tcl_pkg::func_e'(func_i);
  assign in_ready_o = !busy_q;
  assign acc        = in_valid_i && !busy_q;
  assign rd_acc     = acc && (func == tcl_pkg::FN_READ);
  assign load       = busy_q && (!out_valid_q || out_ready_i);

  tcl_cursor u_cursor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .func_i         (func),
    .char_code_i    (char_code_i),
    .scroll_delta_i (scroll_delta_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .upd_o          (upd),
    .st_o           (st)
  );

  assign rphys   = tcl_pkg::phys_row(st.base, read_row_i);
  assign t_raddr = tcl_pkg::ADDR_W'(int'(rphys) * tcl_pkg::COLS + int'(read_col_i));
  assign t_waddr = tcl_pkg::ADDR_W'(int'(upd.wr_row) * tcl_pkg::COLS + int'(upd.wr_col));

  tcl_ram #(
    .AW (tcl_pkg::ADDR_W),
    .DW (tcl_pkg::CH_W)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (upd.text_we),
    .waddr_i (t_waddr),
    .wdata_i (char_code_i),
    .re_i    (rd_acc),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  tcl_ram #(
    .AW (tcl_pkg::ROW_W),
    .DW (tcl_pkg::COL_W)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (upd.len_we),
    .waddr_i (upd.wr_row),
    .wdata_i (upd.len_val),
    .re_i    (rd_acc),
    .raddr_i (rphys),
    .rdata_o (l_rdata)
  );

  // row length valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (upd.clear) begin
      vld_q <= '0;
    end else if (upd.len_we) begin
      vld_q[upd.wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q   <= rd_acc;
      rcol_q <= read_col_i;
      rvld_q <= vld_q[rphys];
      rok_q  <= ({1'b0, read_row_i} < (tcl_pkg::ROW_W+1)'(tcl_pkg::ROWS));
    end
  end

  always_comb begin
    len_sel   = st.col;
    cell_byte = '0;
    if (rd_q) begin
      len_sel = (rok_q && rvld_q) ? l_rdata : '0;
      if ({1'b0, rcol_q} < len_sel) begin
        cell_byte = t_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_row_q  <= st.row;
      o_col_q  <= st.col;
      o_top_q  <= st.top;
      o_len_q  <= len_sel;
      o_cell_q <= cell_byte;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_row_out_o = o_row_q;
  assign cursor_col_out_o = o_col_q;
  assign view_top_out_o   = o_top_q;
  assign row_length_o     = o_len_q;
  assign cell_char_o      = o_cell_q;

endmodule

### design/tcl_ram.sv
// simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps
module tcl_ram #(
  parameter int unsigned AW = 5,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tcl_cursor.sv
// cursor, view top, ring offset and visible row register with store update requests
`timescale 1ns / 1ps
module tcl_cursor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  tcl_pkg::func_e              func_i,
  input  logic [tcl_pkg::CH_W-1:0]    char_code_i,
  input  logic [tcl_pkg::DLT_W-1:0]   scroll_delta_i,
  input  logic                        cfg_we_i,
  input  logic [tcl_pkg::VIS_W-1:0]   cfg_wdata_i,
  output tcl_pkg::upd_t               upd_o,
  output tcl_pkg::cur_t               st_o
);

  logic [tcl_pkg::ROW_W-1:0] row_q, row_d, top_q, top_d, base_q, base_d;
  logic [tcl_pkg::COL_W-1:0] col_q, col_d;
  logic [tcl_pkg::VIS_W-1:0] vis_q, vis_eff;

  logic [tcl_pkg::ROW_W-1:0] or_row, or_top, or_base;
  logic [7:0]                top_vis;
  logic                      wrap;
  logic [tcl_pkg::ROW_W-1:0] p_row, p_base;
  logic [tcl_pkg::COL_W-1:0] p_col;
  logic signed [7:0]         s_top, max_top;
  tcl_pkg::upd_t             upd;

  always_comb begin
    vis_eff = vis_q;
    if (vis_q == '0) begin
      vis_eff = tcl_pkg::VIS_W'(1);
    end else if (vis_q > tcl_pkg::VIS_W'(tcl_pkg::ROWS)) begin
      vis_eff = tcl_pkg::VIS_W'(tcl_pkg::ROWS);
    end
  end

  // fresh row: advance cursor or drop the oldest row
  always_comb begin
    or_row  = row_q;
    or_base = base_q;
    if (row_q != tcl_pkg::ROW_W'(tcl_pkg::ROWS - 1)) begin
      or_row = row_q + 1'b1;
    end else if (base_q == tcl_pkg::ROW_W'(tcl_pkg::ROWS - 1)) begin
      or_base = '0;
    end else begin
      or_base = base_q + 1'b1;
    end
    top_vis = 8'(top_q) + 8'(vis_eff);
    or_top  = top_q;
    if (8'(or_row) >= top_vis) begin
      or_top = tcl_pkg::ROW_W'(8'(or_row) + 8'd1 - 8'(vis_eff));
    end
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    top_d  = top_q;
    base_d = base_q;
    upd    = '0;
    wrap   = (col_q == tcl_pkg::COL_W'(tcl_pkg::COLS));
    p_row  = wrap ? or_row : row_q;
    p_base = wrap ? or_base : base_q;
    p_col  = wrap ? '0 : col_q;
    s_top  = $signed({3'b000, top_q}) + $signed({scroll_delta_i[6], scroll_delta_i});
    max_top = $signed({3'b000, row_q}) - $signed({2'b00, vis_eff}) + 8'sd1;
    if (max_top < 8'sd0) begin
      max_top = 8'sd0;
    end
    if (acc_i) begin
      case (func_i)
        tcl_pkg::FN_PUT: begin
          if (char_code_i == tcl_pkg::CH_NEWLINE) begin
            row_d       = or_row;
            base_d      = or_base;
            top_d       = or_top;
            col_d       = '0;
            upd.len_we  = 1'b1;
            upd.wr_row  = tcl_pkg::phys_row(or_base, or_row);
            upd.len_val = '0;
          end else if (char_code_i == tcl_pkg::CH_BACKSPACE) begin
            if (col_q != '0) begin
              col_d       = col_q - 1'b1;
              upd.len_we  = 1'b1;
              upd.wr_row  = tcl_pkg::phys_row(base_q, row_q);
              upd.len_val = col_q - 1'b1;
            end
          end else begin
            row_d       = p_row;
            base_d      = p_base;
            top_d       = wrap ? or_top : top_q;
            col_d       = p_col + 1'b1;
            upd.text_we = 1'b1;
            upd.len_we  = 1'b1;
            upd.wr_row  = tcl_pkg::phys_row(p_base, p_row);
            upd.wr_col  = p_col;
            upd.len_val = p_col + 1'b1;
          end
        end
        tcl_pkg::FN_SCROLL: begin
          if (s_top < 8'sd0) begin
            top_d = '0;
          end else if (s_top > max_top) begin
            top_d = tcl_pkg::ROW_W'(max_top);
          end else begin
            top_d = tcl_pkg::ROW_W'(s_top);
          end
        end
        tcl_pkg::FN_CLEAR: begin
          row_d     = '0;
          col_d     = '0;
          top_d     = '0;
          base_d    = '0;
          upd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      top_q  <= '0;
      base_q <= '0;
      vis_q  <= tcl_pkg::VIS_RESET;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      top_q  <= top_d;
      base_q <= base_d;
      if (cfg_we_i) begin
        vis_q <= cfg_wdata_i;
      end
    end
  end

  assign upd_o = upd;
  assign st_o  = '{row: row_q, col: col_q, top: top_q, base: base_q};

endmodule
